@@ rtl/core/crcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfb_pkg: shared types, constants and CRC helper for the frame builder
// Holds the register map, status codes, beat structs and the CRC-16 update.
// ----------------------------------------------------------------------------
package crcfb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOF_FIRST   = 2'd0,
        CFG_SOF_SECOND  = 2'd1,
        CFG_HDR_VERSION = 2'd2,
        CFG_MAX_PAYLOAD = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_LONG  = 2'd1,
        STAT_ORDER = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  sof_first;
        logic [7:0]  sof_second;
        logic [7:0]  hdr_version;
        logic [15:0] max_payload;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sof_first:   8'hAA,
        sof_second:  8'h55,
        hdr_version: 8'h01,
        max_payload: 16'd512
    };

    typedef struct packed {
        logic        op;
        logic [7:0]  frame_type;
        logic [7:0]  command;
        logic [7:0]  sequence_req;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
        logic       last_of_run;
    } t_result;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crcfb_if.sv @@
// ----------------------------------------------------------------------------
// crcfb_if: channel interfaces of the frame builder
// Input item, result and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface crcfb_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  frame_type;
    logic [7:0]  command;
    logic [7:0]  sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (
        output valid, op, frame_type, command, sequence_req, payload_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, op, frame_type, command, sequence_req, payload_length, data_byte,
        output ready
    );
endinterface

interface crcfb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
    logic       last_of_run;

    modport source (
        output valid, out_byte, byte_valid, frame_end, status, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, frame_end, status, last_of_run,
        output ready
    );
endinterface

interface crcfb_cfg_if;
    import crcfb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/crcfb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// crcfb_cfg_regs: configuration register file
// Start-of-frame bytes, version byte and payload length limit.
// ----------------------------------------------------------------------------
module crcfb_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_valid,
    output logic                              o_wr_ready,
    input  logic [crcfb_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [crcfb_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output crcfb_pkg::t_cfg                   o_cfg
);
    import crcfb_pkg::*;

    t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_SOF_FIRST:   r_cfg.sof_first   <= i_wr_data[7:0];
                CFG_SOF_SECOND:  r_cfg.sof_second  <= i_wr_data[7:0];
                CFG_HDR_VERSION: r_cfg.hdr_version <= i_wr_data[7:0];
                CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_wr_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/crcfb_in_stage.sv @@
// ----------------------------------------------------------------------------
// crcfb_in_stage: input item register
// Holds one item until the framer takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module crcfb_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  crcfb_pkg::t_item i_item,
    output logic             o_valid,
    output crcfb_pkg::t_item o_item,
    input  logic             i_pop
);
    import crcfb_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_pop;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/core/crcfb_framer.sv @@
// ----------------------------------------------------------------------------
// crcfb_framer: frame sequencer, CRC state and result register
// Expands each item into its result beats, one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module crcfb_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crcfb_pkg::t_cfg    i_cfg,
    input  logic               i_head_valid,
    input  crcfb_pkg::t_item   i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output crcfb_pkg::t_result o_result
);
    import crcfb_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SOF2 = 10'b00_0000_0010,
        ST_VER  = 10'b00_0000_0100,
        ST_TYPE = 10'b00_0000_1000,
        ST_CMD  = 10'b00_0001_0000,
        ST_SEQ  = 10'b00_0010_0000,
        ST_LENL = 10'b00_0100_0000,
        ST_LENH = 10'b00_1000_0000,
        ST_CRCL = 10'b01_0000_0000,
        ST_CRCH = 10'b10_0000_0000
    } t_step;

    t_step       r_step, n_step;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_left, n_left;
    logic        r_open, n_open;
    t_item       r_cur, n_cur;
    logic        r_o_valid;
    t_result     r_o, n_res;
    logic        w_adv, w_fire, w_crc_en;

    assign w_adv    = !r_o_valid || i_ready;
    assign w_fire   = w_adv && ((r_step != ST_IDLE) || i_head_valid);
    assign o_pop    = w_fire && (r_step == ST_IDLE);
    assign o_valid  = r_o_valid;
    assign o_result = r_o;

    always_comb begin
        n_step   = r_step;
        n_crc    = r_crc;
        n_left   = r_left;
        n_open   = r_open;
        n_cur    = r_cur;
        n_res    = '0;
        n_res.status = STAT_OK;
        w_crc_en = 1'b0;
        unique case (r_step)
            ST_IDLE: begin
                if (!i_head.op) begin
                    if (r_open) begin
                        n_res.status      = STAT_ORDER;
                        n_res.last_of_run = 1'b1;
                    end else if (i_head.payload_length > i_cfg.max_payload) begin
                        n_res.status      = STAT_LONG;
                        n_res.last_of_run = 1'b1;
                    end else begin
                        n_res.out_byte   = i_cfg.sof_first;
                        n_res.byte_valid = 1'b1;
                        n_cur            = i_head;
                        n_step           = ST_SOF2;
                    end
                end else if (!r_open) begin
                    n_res.status      = STAT_ORDER;
                    n_res.last_of_run = 1'b1;
                end else begin
                    n_res.out_byte   = i_head.data_byte;
                    n_res.byte_valid = 1'b1;
                    w_crc_en         = 1'b1;
                    n_left           = r_left - 16'd1;
                    // last payload byte: CRC follows
                    if (r_left == 16'd1) begin
                        n_step = ST_CRCL;
                    end else begin
                        n_res.last_of_run = 1'b1;
                    end
                end
            end
            ST_SOF2: begin
                n_res.out_byte   = i_cfg.sof_second;
                n_res.byte_valid = 1'b1;
                n_crc            = CRC_INIT;
                n_step           = ST_VER;
            end
            ST_VER: begin
                n_res.out_byte   = i_cfg.hdr_version;
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                n_step           = ST_TYPE;
            end
            ST_TYPE: begin
                n_res.out_byte   = r_cur.frame_type;
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                n_step           = ST_CMD;
            end
            ST_CMD: begin
                n_res.out_byte   = r_cur.command;
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                n_step           = ST_SEQ;
            end
            ST_SEQ: begin
                n_res.out_byte   = r_cur.sequence_req;
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                n_step           = ST_LENL;
            end
            ST_LENL: begin
                n_res.out_byte   = r_cur.payload_length[7:0];
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                n_step           = ST_LENH;
            end
            ST_LENH: begin
                n_res.out_byte   = r_cur.payload_length[15:8];
                n_res.byte_valid = 1'b1;
                w_crc_en         = 1'b1;
                // empty payload: close the frame straight away
                if (r_cur.payload_length == 16'd0) begin
                    n_step = ST_CRCL;
                end else begin
                    n_open            = 1'b1;
                    n_left            = r_cur.payload_length;
                    n_res.last_of_run = 1'b1;
                    n_step            = ST_IDLE;
                end
            end
            ST_CRCL: begin
                n_res.out_byte   = r_crc[7:0];
                n_res.byte_valid = 1'b1;
                n_step           = ST_CRCH;
            end
            ST_CRCH: begin
                n_res.out_byte    = r_crc[15:8];
                n_res.byte_valid  = 1'b1;
                n_res.frame_end   = 1'b1;
                n_res.last_of_run = 1'b1;
                n_crc             = CRC_INIT;
                n_left            = 16'd0;
                n_open            = 1'b0;
                n_step            = ST_IDLE;
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
        if (w_crc_en) begin
            n_crc = crc_byte(r_crc, n_res.out_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_crc     <= CRC_INIT;
            r_left    <= 16'd0;
            r_open    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_step <= n_step;
                r_crc  <= n_crc;
                r_left <= n_left;
                r_open <= n_open;
            end
            if (w_adv) begin
                r_o_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cur <= n_cur;
            r_o   <= n_res;
        end
    end

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o.frame_end) |-> (r_o.byte_valid && r_o.last_of_run))
        else $error("frame end beat not marked as valid last beat");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o.byte_valid) |->
            (r_o.last_of_run && (r_o.out_byte == 8'h00) && (r_o.status != STAT_OK)))
        else $error("rejected item beat malformed");

    a_close_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_step == ST_CRCH)) |=>
            (!r_open && (r_crc == CRC_INIT) && (r_step == ST_IDLE)))
        else $error("frame state not cleared after CRC");

    a_idle_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_IDLE) && !r_open) |-> (r_crc == CRC_INIT))
        else $error("CRC not at initial value with no frame open");

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_IDLE) && r_open) |-> (r_left != 16'd0))
        else $error("open frame with no payload bytes left");

endmodule

@@ rtl/core/crc16_frame_builder.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_builder: framed serializer with CRC-16 trailer
// Builds start-of-frame, header, payload, CRC and status beats from item beats.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     carries
//  i_item     in   valid/ready   op, frame_type, command, sequence_req,
//                                payload_length, data_byte
//  o_result   out  valid/ready   out_byte, byte_valid, frame_end, status,
//                                last_of_run
//  i_cfg      in   valid/ready   index, data (always ready)
//
//  Beats leave the result register one per cycle; o_result.ready low holds it.
//  A payload item yields its data byte, plus both CRC bytes on the last; a
//  start item yields both start bytes, version, type, command, sequence and
//  both length bytes, plus the CRC bytes with zero length; a rejected item
//  yields a single status beat. Reset is synchronous; no clearing pass follows.
//  The input register keeps one item and refills in the cycle its item is taken.
// ----------------------------------------------------------------------------
module crc16_frame_builder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    crcfb_item_if.sink     i_item,
    crcfb_result_if.source o_result,
    crcfb_cfg_if.sink      i_cfg
);
    import crcfb_pkg::*;

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_head;
    logic    w_head_valid;
    logic    w_pop;
    t_result w_result;

    assign w_in_item.op             = i_item.op;
    assign w_in_item.frame_type     = i_item.frame_type;
    assign w_in_item.command        = i_item.command;
    assign w_in_item.sequence_req   = i_item.sequence_req;
    assign w_in_item.payload_length = i_item.payload_length;
    assign w_in_item.data_byte      = i_item.data_byte;

    crcfb_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    crcfb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_item  (w_in_item),
        .o_valid (w_head_valid),
        .o_item  (w_head),
        .i_pop   (w_pop)
    );

    crcfb_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_result     (w_result)
    );

    assign o_result.out_byte    = w_result.out_byte;
    assign o_result.byte_valid  = w_result.byte_valid;
    assign o_result.frame_end   = w_result.frame_end;
    assign o_result.status      = w_result.status;
    assign o_result.last_of_run = w_result.last_of_run;

endmodule

@@ bench/crcfb_wire_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crcfb_wire_checker: predicts and checks the serialized frame bytes
// Watches the item, result and register channels, rebuilds every frame with
// its own CRC-16 and compares each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module crcfb_wire_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_item_valid,
    input  logic                             i_item_ready,
    input  logic                             i_item_op,
    input  logic [7:0]                       i_item_frame_type,
    input  logic [7:0]                       i_item_command,
    input  logic [7:0]                       i_item_sequence_req,
    input  logic [15:0]                      i_item_payload_length,
    input  logic [7:0]                       i_item_data_byte,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [7:0]                       i_res_out_byte,
    input  logic                             i_res_byte_valid,
    input  logic                             i_res_frame_end,
    input  logic [1:0]                       i_res_status,
    input  logic                             i_res_last_of_run,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [crcfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import crcfb_pkg::*;

    logic [7:0]  sof_a;
    logic [7:0]  sof_b;
    logic [7:0]  version_byte;
    logic [15:0] payload_limit;

    logic [15:0] frame_crc;
    logic [15:0] frame_remaining;
    logic        frame_active;

    t_result     wire_bytes_due[$];
    int          fail_total;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int k = 7; k >= 0; k--) begin
            feedback = acc[15] ^ b[k];
            acc = {acc[14:0], 1'b0};
            if (feedback) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic t_result make_beat(input logic [7:0] b, input logic v, input logic e,
                                          input t_status st);
        t_result r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.frame_end   = e;
        r.status      = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic serialize_item(input t_item it);
        t_result    beats[10];
        logic [7:0] hdr[6];
        int         n;
        logic       closing;
        n = 0;
        closing = 1'b0;
        if (!it.op) begin
            if (frame_active) begin
                beats[0] = make_beat(8'h00, 1'b0, 1'b0, STAT_ORDER);
                n = 1;
            end else if (it.payload_length > payload_limit) begin
                beats[0] = make_beat(8'h00, 1'b0, 1'b0, STAT_LONG);
                n = 1;
            end else begin
                hdr[0] = version_byte;
                hdr[1] = it.frame_type;
                hdr[2] = it.command;
                hdr[3] = it.sequence_req;
                hdr[4] = it.payload_length[7:0];
                hdr[5] = it.payload_length[15:8];
                beats[0] = make_beat(sof_a, 1'b1, 1'b0, STAT_OK);
                beats[1] = make_beat(sof_b, 1'b1, 1'b0, STAT_OK);
                frame_crc = CRC_INIT;
                for (int i = 0; i < 6; i++) begin
                    frame_crc = crc16_step(frame_crc, hdr[i]);
                    beats[2 + i] = make_beat(hdr[i], 1'b1, 1'b0, STAT_OK);
                end
                n = 8;
                if (it.payload_length == 16'd0) begin
                    closing = 1'b1;
                end else begin
                    frame_remaining = it.payload_length;
                    frame_active = 1'b1;
                end
            end
        end else begin
            if (!frame_active) begin
                beats[0] = make_beat(8'h00, 1'b0, 1'b0, STAT_ORDER);
                n = 1;
            end else begin
                frame_crc = crc16_step(frame_crc, it.data_byte);
                beats[0] = make_beat(it.data_byte, 1'b1, 1'b0, STAT_OK);
                n = 1;
                frame_remaining = frame_remaining - 16'd1;
                closing = (frame_remaining == 16'd0);
            end
        end
        // trailer goes out low byte first, then the frame closes
        if (closing) begin
            beats[n] = make_beat(frame_crc[7:0], 1'b1, 1'b0, STAT_OK);
            beats[n + 1] = make_beat(frame_crc[15:8], 1'b1, 1'b1, STAT_OK);
            n = n + 2;
            frame_crc = CRC_INIT;
            frame_remaining = 16'd0;
            frame_active = 1'b0;
        end
        beats[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) begin
            wire_bytes_due.push_back(beats[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_item   it;
        if (!i_rst_n) begin
            sof_a           = CFG_RESET.sof_first;
            sof_b           = CFG_RESET.sof_second;
            version_byte    = CFG_RESET.hdr_version;
            payload_limit   = CFG_RESET.max_payload;
            frame_crc       = CRC_INIT;
            frame_remaining = 16'd0;
            frame_active    = 1'b0;
            wire_bytes_due.delete();
        end else begin
            // check results first: a beat leaving now belongs to an older item
            if (i_res_valid && i_res_ready) begin
                got.out_byte    = i_res_out_byte;
                got.byte_valid  = i_res_byte_valid;
                got.frame_end   = i_res_frame_end;
                got.status      = i_res_status;
                got.last_of_run = i_res_last_of_run;
                if (wire_bytes_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: unexpected beat: byte %02h v %0b end %0b st %0d last %0b",
                                 $realtime, got.out_byte, got.byte_valid, got.frame_end,
                                 got.status, got.last_of_run);
                    end
                end else begin
                    want = wire_bytes_due.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.frame_end !== want.frame_end || got.status !== want.status ||
                        got.last_of_run !== want.last_of_run) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: mismatch exp byte %02h v %0b end %0b st %0d last %0b",
                                     $realtime, want.out_byte, want.byte_valid, want.frame_end,
                                     want.status, want.last_of_run);
                            $display("%0t:          got byte %02h v %0b end %0b st %0d last %0b",
                                     $realtime, got.out_byte, got.byte_valid, got.frame_end,
                                     got.status, got.last_of_run);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SOF_FIRST:   sof_a = i_cfg_data[7:0];
                    CFG_SOF_SECOND:  sof_b = i_cfg_data[7:0];
                    CFG_HDR_VERSION: version_byte = i_cfg_data[7:0];
                    CFG_MAX_PAYLOAD: payload_limit = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_item_valid && i_item_ready) begin
                it.op             = i_item_op;
                it.frame_type     = i_item_frame_type;
                it.command        = i_item_command;
                it.sequence_req   = i_item_sequence_req;
                it.payload_length = i_item_payload_length;
                it.data_byte      = i_item_data_byte;
                serialize_item(it);
            end
        end
        o_pending    = wire_bytes_due.size();
        o_fail_count = fail_total;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: frame builder stimulus and verdict
// Drives register writes, start and payload items with random gaps and a long
// receiver hold-off; the checker beside the block predicts every byte.
// ----------------------------------------------------------------------------
module testbench;
    import crcfb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          beats_due;
    int          items_sent;
    bit          gaps_on;
    bit          pressure_req;
    int          hold_left;

    crcfb_item_if   item_ch ();
    crcfb_result_if result_ch ();
    crcfb_cfg_if    cfg_ch ();

    crc16_frame_builder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    crcfb_wire_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_item_valid          (item_ch.valid),
        .i_item_ready          (item_ch.ready),
        .i_item_op             (item_ch.op),
        .i_item_frame_type     (item_ch.frame_type),
        .i_item_command        (item_ch.command),
        .i_item_sequence_req   (item_ch.sequence_req),
        .i_item_payload_length (item_ch.payload_length),
        .i_item_data_byte      (item_ch.data_byte),
        .i_res_valid           (result_ch.valid),
        .i_res_ready           (result_ch.ready),
        .i_res_out_byte        (result_ch.out_byte),
        .i_res_byte_valid      (result_ch.byte_valid),
        .i_res_frame_end       (result_ch.frame_end),
        .i_res_status          (result_ch.status),
        .i_res_last_of_run     (result_ch.last_of_run),
        .i_cfg_valid           (cfg_ch.valid),
        .i_cfg_ready           (cfg_ch.ready),
        .i_cfg_index           (cfg_ch.index),
        .i_cfg_data            (cfg_ch.data),
        .o_fail_count          (fail_count),
        .o_pending             (beats_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when asked for one
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left = 299;
                result_ch.ready = 1'b0;
            end else begin
                result_ch.ready = !(gaps_on && $urandom_range(0, 99) < 13);
            end
        end
    end

    function automatic t_item make_start(input logic [7:0] ftype, input logic [7:0] cmd,
                                         input logic [7:0] seq, input logic [15:0] len);
        t_item it;
        it.op             = 1'b0;
        it.frame_type     = ftype;
        it.command        = cmd;
        it.sequence_req   = seq;
        it.payload_length = len;
        it.data_byte      = 8'($urandom);
        return it;
    endfunction

    function automatic t_item make_payload(input logic [7:0] data);
        t_item it;
        it.op             = 1'b1;
        it.frame_type     = 8'($urandom);
        it.command        = 8'($urandom);
        it.sequence_req   = 8'($urandom);
        it.payload_length = 16'($urandom);
        it.data_byte      = data;
        return it;
    endfunction

    function automatic logic [15:0] frame_length(input logic [15:0] limit);
        int cap;
        cap = ($urandom_range(0, 14) == 0) ? 40 : 10;
        if (int'(limit) < cap) begin
            cap = int'(limit);
        end
        return 16'($urandom_range(0, cap));
    endfunction

    // Called just after a falling edge; returns just after a falling edge, once the item is taken
    task automatic send_item(input t_item it);
        while (gaps_on && $urandom_range(0, 99) < 13) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid          = 1'b1;
        item_ch.op             = it.op;
        item_ch.frame_type     = it.frame_type;
        item_ch.command        = it.command;
        item_ch.sequence_req   = it.sequence_req;
        item_ch.payload_length = it.payload_length;
        item_ch.data_byte      = it.data_byte;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_item(make_start(8'($urandom), 8'($urandom), 8'($urandom), len));
        for (int k = 0; k < int'(len); k++) begin
            // misplaced start: must be refused while the frame stays open
            if ($urandom_range(0, 24) == 0) begin
                send_item(make_start(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)));
            end
            send_item(make_payload(8'($urandom)));
        end
    endtask

    task automatic settle();
        item_ch.valid = 1'b0;
        while (beats_due != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic reconfigure(input logic [15:0] limit);
        settle();
        cfg_write(CFG_SOF_FIRST, 16'($urandom));
        cfg_write(CFG_SOF_SECOND, 16'($urandom));
        cfg_write(CFG_HDR_VERSION, 16'($urandom));
        cfg_write(CFG_MAX_PAYLOAD, limit);
    endtask

    task automatic run_traffic(input int quota, input logic [15:0] limit);
        int stop_at;
        int pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_frame(frame_length(limit));
            end else if (pick < 88 && limit != 16'hFFFF) begin
                send_item(make_start(8'($urandom), 8'($urandom), 8'($urandom),
                                     16'($urandom_range(int'(limit) + 1, 65535))));
            end else begin
                send_item(make_payload(8'($urandom)));
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] limit;
        i_rst_n                = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.op             = 1'b0;
        item_ch.frame_type     = 8'h00;
        item_ch.command        = 8'h00;
        item_ch.sequence_req   = 8'h00;
        item_ch.payload_length = 16'h0000;
        item_ch.data_byte      = 8'h00;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_SOF_FIRST;
        cfg_ch.data            = '0;
        gaps_on                = 1'b1;
        pressure_req           = 1'b0;
        hold_left              = 0;
        items_sent             = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register values out of reset; empty frame, strays, a short frame and an overlong start
        send_item(make_start(8'hFF, 8'h00, 8'hFF, 16'd0));
        send_item(make_payload(8'hFF));
        send_item(make_start(8'h00, 8'hFF, 8'h00, 16'd2));
        send_item(make_start(8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_item(make_payload(8'h00));
        send_item(make_payload(8'hFF));
        send_item(make_start(8'h5A, 8'hA5, 8'h3C, 16'd513));

        // Zero limit: only empty frames pass
        settle();
        cfg_write(CFG_SOF_FIRST, 16'h0000);
        cfg_write(CFG_SOF_SECOND, 16'h00FF);
        cfg_write(CFG_HDR_VERSION, 16'h00FF);
        cfg_write(CFG_MAX_PAYLOAD, 16'h0000);
        send_item(make_start(8'h12, 8'h34, 8'h56, 16'd0));
        send_item(make_start(8'h12, 8'h34, 8'h56, 16'd1));

        // Length right at the limit, then one over and the largest length
        settle();
        cfg_write(CFG_SOF_FIRST, 16'h00FF);
        cfg_write(CFG_SOF_SECOND, 16'h0000);
        cfg_write(CFG_HDR_VERSION, 16'h0000);
        cfg_write(CFG_MAX_PAYLOAD, 16'd3);
        send_item(make_start(8'h81, 8'h7E, 8'hC3, 16'd3));
        send_item(make_payload(8'hFF));
        send_item(make_payload(8'h00));
        send_item(make_payload(8'($urandom)));
        send_item(make_start(8'h81, 8'h7E, 8'hC3, 16'd4));
        send_item(make_start(8'h81, 8'h7E, 8'hC3, 16'hFFFF));

        limit = 16'($urandom_range(0, 15));
        reconfigure(limit);
        run_traffic(35, limit);

        // Full limit; stall the receiver over a frame with a high length byte
        reconfigure(16'hFFFF);
        @(posedge i_clk);
        pressure_req = 1'b1;
        @(negedge i_clk);
        send_frame(16'd258);
        run_traffic(10, 16'hFFFF);

        limit = 16'($urandom_range(0, 65535));
        reconfigure(limit);
        gaps_on = 1'b0;
        run_traffic(45, limit);
        gaps_on = 1'b1;

        reconfigure(16'd1);
        run_traffic(30, 16'd1);

        limit = 16'($urandom_range(16, 60));
        reconfigure(limit);
        run_traffic(30, limit);

        settle();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && beats_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crcfb_pkg.sv
rtl/core/crcfb_if.sv
rtl/core/crcfb_cfg_regs.sv
rtl/core/crcfb_in_stage.sv
rtl/core/crcfb_framer.sv
rtl/core/crc16_frame_builder.sv
bench/crcfb_wire_checker.sv
bench/testbench.sv
